// ===== rtl/core/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned DataWidth   = 8;
    localparam int unsigned OpWidth     = 4;
    localparam int unsigned LenWidth    = 32;
    localparam int unsigned CntWidth    = 4;
    localparam int unsigned KeyLanes    = 4;
    localparam int unsigned KeyIdxWidth = $clog2(KeyLanes);

    localparam logic [LenWidth-1:0] MaxPayloadReset = 32'd4096;

    localparam logic [OpWidth-1:0] OpPing   = 4'h9;
    localparam logic [6:0]         Len7Ext16 = 7'd126;
    localparam logic [6:0]         Len7Ext64 = 7'd127;
    localparam logic [CntWidth-1:0] Ext16Bytes = 4'd2;
    localparam logic [CntWidth-1:0] Ext64Bytes = 4'd8;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [DataWidth-1:0] data_byte;
        logic                 last;
        logic                 empty_frame;
        logic                 length_error;
        logic [OpWidth-1:0]   frame_opcode;
        logic                 pong_request;
    } result_t;

    // handshake item from the input stage to the parser
    typedef struct packed {
        logic                 valid;
        logic [DataWidth-1:0] rx_byte;
    } in_item_t;

endpackage

// ===== rtl/core/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    input  logic                   take,
    output wsd_pkg::in_item_t      item
);
    import wsd_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [DataWidth-1:0] byte_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

// ===== rtl/core/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine, length check, key capture and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  wsd_pkg::in_item_t      item,
    input  logic                   out_free,
    output logic                   take,
    output logic                   res_valid,
    output wsd_pkg::result_t       res
);
    import wsd_pkg::*;

    phase_t                           phase_reg,   phase_next;
    logic [OpWidth-1:0]               opcode_reg,  opcode_next;
    logic                             masked_reg,  masked_next;
    logic [LenWidth-1:0]              len_reg,     len_next;
    logic                             len_hi_reg,  len_hi_next;
    logic [CntWidth-1:0]              left_reg,    left_next;
    logic [KeyLanes-1:0][DataWidth-1:0] key_reg,   key_next;
    logic [KeyIdxWidth-1:0]           kidx_reg,    kidx_next;
    logic [KeyIdxWidth-1:0]           pidx_reg,    pidx_next;
    logic [LenWidth-1:0]              remain_reg,  remain_next;
    logic [LenWidth-1:0]              max_reg;

    logic [DataWidth-1:0] b;
    logic                 len_done;
    logic                 begin_pl;
    logic [LenWidth-1:0]  begin_len;
    logic [CntWidth-1:0]  left_dec;
    logic                 fin;

    assign take = item.valid && out_free;
    assign b    = item.rx_byte;

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        len_hi_next = len_hi_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        pidx_next   = pidx_reg;
        remain_next = remain_reg;
        len_done    = 1'b0;
        begin_pl    = 1'b0;
        begin_len   = len_reg;
        left_dec    = left_reg - CntWidth'(1);
        fin         = 1'b0;

        res_valid        = 1'b0;
        res.data_byte    = '0;
        res.last         = 1'b0;
        res.empty_frame  = 1'b0;
        res.length_error = 1'b0;
        res.frame_opcode = opcode_reg;
        res.pong_request = 1'b0;

        case (phase_reg)
            PH_HDR1: begin
                masked_next = b[7];
                len_hi_next = 1'b0;
                if (b[6:0] == Len7Ext16) begin
                    len_next   = '0;
                    left_next  = Ext16Bytes;
                    phase_next = PH_EXT;
                end else if (b[6:0] == Len7Ext64) begin
                    len_next   = '0;
                    left_next  = Ext64Bytes;
                    phase_next = PH_EXT;
                end else begin
                    len_next = {{(LenWidth-7){1'b0}}, b[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                // bytes shifted past the low word only matter as "too long"
                len_hi_next = len_hi_reg || (len_reg[LenWidth-1 -: DataWidth] != '0);
                len_next    = {len_reg[LenWidth-DataWidth-1:0], b};
                left_next   = left_dec;
                len_done    = (left_dec == '0);
            end
            PH_KEY: begin
                key_next[kidx_reg] = b;
                kidx_next          = kidx_reg + KeyIdxWidth'(1);
                if (kidx_reg == KeyIdxWidth'(KeyLanes - 1)) begin
                    begin_pl = 1'b1;
                end
            end
            PH_DATA: begin
                fin         = (remain_reg == LenWidth'(1));
                remain_next = remain_reg - LenWidth'(1);
                pidx_next   = pidx_reg + KeyIdxWidth'(1);
                res_valid   = 1'b1;
                res.data_byte = masked_reg ? (b ^ key_reg[pidx_reg]) : b;
                res.last      = fin;
                res.pong_request = fin && (opcode_reg == OpPing);
                if (fin) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                opcode_next = b[OpWidth-1:0];
                phase_next  = PH_HDR1;
            end
        endcase

        if (len_done) begin
            if (len_hi_next || (len_next >= max_reg)) begin
                phase_next       = PH_HDR0;
                res_valid        = 1'b1;
                res.last         = 1'b1;
                res.length_error = 1'b1;
            end else if (masked_next) begin
                kidx_next  = '0;
                phase_next = PH_KEY;
            end else begin
                begin_pl  = 1'b1;
                begin_len = len_next;
            end
        end

        if (begin_pl) begin
            if (begin_len == '0) begin
                phase_next       = PH_HDR0;
                res_valid        = 1'b1;
                res.last         = 1'b1;
                res.empty_frame  = 1'b1;
                res.pong_request = (opcode_reg == OpPing);
            end else begin
                remain_next = begin_len;
                pidx_next   = '0;
                phase_next  = PH_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            len_hi_reg <= 1'b0;
            left_reg   <= '0;
            kidx_reg   <= '0;
            pidx_reg   <= '0;
            max_reg    <= MaxPayloadReset;
        end else begin
            if (take) begin
                phase_reg  <= phase_next;
                opcode_reg <= opcode_next;
                masked_reg <= masked_next;
                len_hi_reg <= len_hi_next;
                left_reg   <= left_next;
                kidx_reg   <= kidx_next;
                pidx_reg   <= pidx_next;
            end
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            len_reg    <= len_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  logic                   res_valid,
    input  wsd_pkg::result_t       res,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wsd_pkg::result_t       m_res
);
    import wsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: one stream byte in, payload bytes out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle at a sustained rate while m_ready keeps up; a byte
// passes the input register, then the header state machine and unmasking
// logic, and its result is captured in the result register, which raises
// m_valid. The rate is set by the parser's single state update per byte;
// while a result waits on m_ready the parser holds and s_ready drops once the
// input register is full.
// Header, length and key bytes produce no payload result; each payload byte
// produces one, the last marked with m_last. Zero-length frames give one
// m_empty_frame result; lengths at or above max_payload (cfg_wdata, reset
// 4096) give one m_length_error result, after which parsing restarts at a
// header byte. Write max_payload only while the block is idle.
module websocket_frame_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last,
    output logic       m_empty_frame,
    output logic       m_length_error,
    output logic [3:0] m_frame_opcode,
    output logic       m_pong_request
);
    import wsd_pkg::*;

    in_item_t item;
    logic     take;
    logic     out_free;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    wsd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (take),
        .item      (item)
    );

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .out_free  (out_free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_data_byte    = m_res.data_byte;
    assign m_last         = m_res.last;
    assign m_empty_frame  = m_res.empty_frame;
    assign m_length_error = m_res.length_error;
    assign m_frame_opcode = m_res.frame_opcode;
    assign m_pong_request = m_res.pong_request;

endmodule

// ===== rtl/core/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module wsd_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data_byte,
    input  logic       m_last,
    input  logic       m_empty_frame,
    input  logic       m_length_error,
    input  logic [3:0] m_frame_opcode,
    input  logic       m_pong_request
);
    import wsd_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte) && $stable(m_last)
            && $stable(m_empty_frame) && $stable(m_length_error))
        else $error("result changed while stalled");

    a_special_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_empty_frame || m_length_error) |-> m_last && (m_data_byte == '0))
        else $error("empty or error result not a lone last transfer");

    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_empty_frame && m_length_error))
        else $error("empty and error flagged together");

    a_pong: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pong_request |-> m_last && (m_frame_opcode == OpPing) && !m_length_error)
        else $error("pong request outside the last transfer of a ping");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_data_byte    (m_data_byte),
    .m_last         (m_last),
    .m_empty_frame  (m_empty_frame),
    .m_length_error (m_length_error),
    .m_frame_opcode (m_frame_opcode),
    .m_pong_request (m_pong_request)
);

// ===== verif/websocket_frame_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches both channels of the deframer, predicts the results of each
// transferred byte with its own frame parser, and compares every result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_data_byte,
    input  logic        m_last,
    input  logic        m_empty_frame,
    input  logic        m_length_error,
    input  logic [3:0]  m_frame_opcode,
    input  logic        m_pong_request,
    output int          error_count,
    output int          pending,
    output logic        at_header
);
    import wsd_pkg::*;

    phase_t      parse_phase = PH_HDR0;
    logic [3:0]  frame_op = '0;
    logic        masked = 1'b0;
    logic [63:0] frame_len = '0;
    logic [3:0]  len_bytes_left = '0;
    logic [31:0] key_word = '0;
    logic [2:0]  key_count = '0;
    logic [63:0] byte_index = '0;
    logic [31:0] max_payload = MaxPayloadReset;

    result_t     expected_results[$];
    int          queued_count = 0;
    int          fails = 0;

    assign error_count = fails;
    assign pending     = queued_count;
    assign at_header   = (parse_phase == PH_HDR0);

    task automatic add_expected(input logic [7:0] data, input logic fin, input logic empty,
                                input logic err, input logic pong);
        result_t r;
        r.data_byte    = data;
        r.last         = fin;
        r.empty_frame  = empty;
        r.length_error = err;
        r.frame_opcode = frame_op;
        r.pong_request = pong;
        expected_results.push_back(r);
    endtask

    task automatic open_payload();
        if (frame_len == 0) begin
            parse_phase = PH_HDR0;
            add_expected(8'h00, 1'b1, 1'b1, 1'b0, frame_op == OpPing);
        end else begin
            byte_index  = '0;
            parse_phase = PH_DATA;
        end
    endtask

    // the length is judged before any masking key arrives
    task automatic close_length();
        if (frame_len >= 64'(max_payload)) begin
            parse_phase = PH_HDR0;
            add_expected(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
        end else if (masked) begin
            key_word    = '0;
            key_count   = '0;
            parse_phase = PH_KEY;
        end else begin
            open_payload();
        end
    endtask

    task automatic parse_byte(input logic [7:0] rx);
        logic [7:0] plain;
        logic       fin;
        case (parse_phase)
            PH_HDR1: begin
                masked    = rx[7];
                frame_len = '0;
                if (rx[6:0] == Len7Ext16) begin
                    len_bytes_left = Ext16Bytes;
                    parse_phase    = PH_EXT;
                end else if (rx[6:0] == Len7Ext64) begin
                    len_bytes_left = Ext64Bytes;
                    parse_phase    = PH_EXT;
                end else begin
                    frame_len = 64'(rx[6:0]);
                    close_length();
                end
            end
            PH_EXT: begin
                frame_len = {frame_len[55:0], rx};
                if (len_bytes_left != 0) len_bytes_left--;
                if (len_bytes_left == 0) close_length();
            end
            PH_KEY: begin
                key_word = key_word | (32'(rx) << (8 * key_count[1:0]));
                key_count++;
                if (key_count >= 3'd4) begin
                    key_count = '0;
                    open_payload();
                end
            end
            PH_DATA: begin
                plain = masked ? rx ^ key_word[8*byte_index[1:0] +: 8] : rx;
                byte_index++;
                fin = (byte_index >= frame_len);
                if (fin) parse_phase = PH_HDR0;
                add_expected(plain, fin, 1'b0, 1'b0, fin && frame_op == OpPing);
            end
            default: begin
                frame_op    = rx[3:0];
                parse_phase = PH_HDR1;
            end
        endcase
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want === got) return 0;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1;
    endfunction

    task automatic check_result();
        result_t want;
        int      bad;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got data %0h last %0b",
                     $time, m_data_byte, m_last);
            $display("%0t:   empty %0b err %0b op %0h pong %0b",
                     $time, m_empty_frame, m_length_error, m_frame_opcode, m_pong_request);
            fails++;
        end else begin
            want = expected_results.pop_front();
            bad  = 0;
            bad += field_mismatch("m_data_byte", 32'(want.data_byte), 32'(m_data_byte));
            bad += field_mismatch("m_last", 32'(want.last), 32'(m_last));
            bad += field_mismatch("m_empty_frame", 32'(want.empty_frame),
                                  32'(m_empty_frame));
            bad += field_mismatch("m_length_error", 32'(want.length_error),
                                  32'(m_length_error));
            bad += field_mismatch("m_frame_opcode", 32'(want.frame_opcode),
                                  32'(m_frame_opcode));
            bad += field_mismatch("m_pong_request", 32'(want.pong_request),
                                  32'(m_pong_request));
            if (bad != 0) fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase    = PH_HDR0;
            frame_op       = '0;
            masked         = 1'b0;
            frame_len      = '0;
            len_bytes_left = '0;
            key_word       = '0;
            key_count      = '0;
            byte_index     = '0;
            max_payload    = MaxPayloadReset;
            expected_results.delete();
        end else begin
            if (cfg_we) max_payload = cfg_wdata;
            if (s_valid && s_ready) parse_byte(s_rx_byte);
            if (m_valid && m_ready) check_result();
        end
        queued_count = expected_results.size();
    end

endmodule

// ===== verif/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Feeds frame byte streams into the deframer with random gaps and output
// stalls, across several max_payload settings, and reports the checker's
// verdict.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int ClkHalf      = 10;
    localparam int ResetCycles  = 12;
    localparam int CycleLimit   = 500000;
    localparam int DrainCycles  = 10;
    localparam int PressureAt   = 150;
    localparam int PressureHold = 400;

    localparam logic [3:0] FinFlags  = 4'h8;
    localparam logic [3:0] OpText    = 4'h1;
    localparam logic [3:0] OpBinary  = 4'h2;
    localparam logic [3:0] OpClose   = 4'h8;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_data_byte;
    logic        m_last;
    logic        m_empty_frame;
    logic        m_length_error;
    logic [3:0]  m_frame_opcode;
    logic        m_pong_request;

    int          error_count;
    int          pending;
    logic        at_header;

    logic [7:0]  tx_queue[$];
    int          bytes_queued   = 0;
    int          bytes_accepted = 0;
    logic [31:0] cur_max        = MaxPayloadReset;
    logic        in_fire        = 1'b0;
    int          cycle_count    = 0;
    bit          src_burst      = 1'b0;
    bit          sink_burst     = 1'b0;

    always #(ClkHalf) aclk = ~aclk;

    websocket_frame_deframer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_last         (m_last),
        .m_empty_frame  (m_empty_frame),
        .m_length_error (m_length_error),
        .m_frame_opcode (m_frame_opcode),
        .m_pong_request (m_pong_request)
    );

    websocket_frame_deframer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_last         (m_last),
        .m_empty_frame  (m_empty_frame),
        .m_length_error (m_length_error),
        .m_frame_opcode (m_frame_opcode),
        .m_pong_request (m_pong_request),
        .error_count    (error_count),
        .pending        (pending),
        .at_header      (at_header)
    );

    always @(posedge aclk) in_fire <= s_valid && s_ready;

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int idle_len(inout bit burst);
        int r;
        if ($urandom_range(0, 49) == 0) burst = ~burst;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        tx_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [3:0] op, input bit mask_on, input logic [63:0] len,
                               input bit with_body);
        len_form_t  form;
        logic [6:0] len7;
        int         n_ext;
        if (len < 126) form = len_form_t'($urandom_range(0, 2));
        else if (len <= 64'hFFFF) form = $urandom_range(0, 1) ? LEN_EXT64 : LEN_EXT16;
        else form = LEN_EXT64;
        len7  = (form == LEN_SHORT) ? len[6:0] : (form == LEN_EXT16) ? Len7Ext16 : Len7Ext64;
        n_ext = (form == LEN_EXT16) ? 2 : (form == LEN_EXT64) ? 8 : 0;
        queue_byte({4'($urandom), op});
        queue_byte({mask_on, len7});
        for (int i = n_ext - 1; i >= 0; i--) queue_byte(len[8*i +: 8]);
        if (with_body) begin
            if (mask_on) repeat (4) queue_byte(8'($urandom));
            for (longint unsigned i = 0; i < len; i++) queue_byte(8'($urandom));
        end
    endtask

    task automatic queue_random_frame(input bit allow_noise);
        int unsigned pick;
        logic [3:0]  op;
        bit          mask_on;
        logic [63:0] len;
        logic [63:0] room;
        pick    = $urandom_range(0, 99);
        op      = ($urandom_range(0, 4) == 0) ? OpPing : 4'($urandom);
        mask_on = 1'($urandom_range(0, 1));
        room    = 64'(cur_max) - 1;
        if (allow_noise && pick < 10) begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
        end else if (pick < 22) begin
            // rejected length; key and payload are sent only as a broken sequence
            if ($urandom_range(0, 2) == 0)
                len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            else
                len = 64'(cur_max) + 64'($urandom_range(0, 3));
            queue_frame(op, mask_on, len, allow_noise && len <= 300 && $urandom_range(0, 1));
        end else if (pick < 32 || room == 0) begin
            queue_frame(op, mask_on, 64'd0, 1'b1);
        end else begin
            if (pick < 40 && room <= 300) begin
                len = room;
            end else begin
                case ($urandom_range(0, 9))
                    0:       len = 64'($urandom_range(126, 300));
                    1, 2:    len = 64'($urandom_range(9, 40));
                    default: len = 64'($urandom_range(1, 8));
                endcase
                if (len > room) len = 64'($urandom_range(1, 32'(room)));
            end
            queue_frame(op, mask_on, len, 1'b1);
        end
    endtask

    task automatic queue_random_bytes(input int target, input bit allow_noise);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target) queue_random_frame(allow_noise);
    endtask

    task automatic write_max_payload(input logic [31:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cur_max   = value;
    endtask

    // drain the stream, pad with zero bytes until a frame boundary, then settle
    task automatic finish_phase();
        wait (bytes_accepted == bytes_queued);
        while (!at_header) begin
            queue_byte(8'h00);
            wait (bytes_accepted == bytes_queued);
        end
        wait (pending == 0);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    initial begin : byte_driver
        int idle_left;
        idle_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (s_valid && in_fire) begin
                s_valid = 1'b0;
                bytes_accepted++;
                idle_left = idle_len(src_burst);
            end
            if (!s_valid) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (tx_queue.size() != 0) begin
                    s_rx_byte = tx_queue.pop_front();
                    s_valid   = 1'b1;
                end
            end
        end
    end

    initial begin : result_sink
        int hold_left;
        bit pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            // hold off for a long stretch once so the block backs up its input
            if (!pressure_done && bytes_accepted >= PressureAt) begin
                hold_left     = PressureHold;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready   = 1'b1;
                hold_left = idle_len(sink_burst);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (ResetCycles) @(negedge aclk);
        aresetn = 1'b1;

        // unmasked text frame, payload byte at the top of the range
        queue_byte({FinFlags, OpText});
        queue_byte(8'h01);
        queue_byte(8'hFF);
        // masked ping with one payload byte
        queue_byte({FinFlags, OpPing});
        queue_byte(8'h81);
        queue_byte(8'hA5);
        queue_byte(8'h5A);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'h00);
        // zero-length ping: one empty result with a pong request
        queue_byte({FinFlags, OpPing});
        queue_byte(8'h00);
        // zero-length masked frame: key still follows the header
        queue_byte({FinFlags, OpBinary});
        queue_byte(8'h80);
        repeat (4) queue_byte(8'h3C);
        // 16-bit length equal to max_payload: rejected, back to a header
        queue_byte({FinFlags, OpClose});
        queue_byte({1'b0, Len7Ext16});
        queue_byte(MaxPayloadReset[15:8]);
        queue_byte(MaxPayloadReset[7:0]);
        // 64-bit length of all ones: rejected
        queue_byte(8'h0F);
        queue_byte({1'b1, Len7Ext64});
        repeat (8) queue_byte(8'hFF);
        finish_phase();

        // only zero-length frames get through
        write_max_payload(32'd1);
        queue_random_bytes(60, 1'b1);
        finish_phase();

        write_max_payload(32'hFFFF_FFFF);
        queue_random_bytes(260, 1'b0);
        finish_phase();

        write_max_payload($urandom_range(2, 200));
        queue_random_bytes(260, 1'b1);
        finish_phase();

        write_max_payload(MaxPayloadReset);
        queue_random_bytes(120, 1'b0);
        finish_phase();

        if (error_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== websocket_frame_deframer.f =====
rtl/core/wsd_pkg.sv
rtl/core/wsd_in_stage.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_stage.sv
rtl/core/websocket_frame_deframer.sv
rtl/core/wsd_checker.sv
verif/websocket_frame_deframer_checker.sv
verif/websocket_frame_deframer_tb.sv
